@@ design/kf_pkg.sv @@
// Shared types and constants for the three-axis scalar Kalman filter core.
// No dependencies; imported by the interfaces, every module and the checker.
package kf_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int NOISE_AXES = 3;
  localparam int EST_W      = 32;
  localparam int VAR_W      = 24;
  localparam int PRED_W     = VAR_W + 1;
  localparam int DEN_W      = VAR_W + 2;
  localparam int REM_W      = VAR_W + 3;
  localparam int GAIN_W     = 17;
  localparam int DIV_STEPS  = GAIN_W;

  localparam logic [4:0]        DIV_LAST     = 5'(DIV_STEPS - 1);
  localparam logic [GAIN_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [VAR_W-1:0]  VAR_RESET    = 24'd6554;
  localparam logic [VAR_W-1:0]  VAR_SAT      = 24'hFFFFFF;
  localparam logic [VAR_W-1:0]  PNOISE_RESET = 24'd3277;
  localparam logic [VAR_W-1:0]  MNOISE_RESET = 24'd6554;
  localparam logic [VAR_W-1:0]  PSTART_RESET = 24'd6554;
  localparam logic [EST_W-1:0]  XSTART_RESET = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROC_X  = 4'd0,
    REG_PROC_Y  = 4'd1,
    REG_PROC_Z  = 4'd2,
    REG_MEAS_X  = 4'd3,
    REG_MEAS_Y  = 4'd4,
    REG_MEAS_Z  = 4'd5,
    REG_P_START = 4'd6,
    REG_X_START = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [NOISE_AXES-1:0][VAR_W-1:0] proc_noise;
    logic [NOISE_AXES-1:0][VAR_W-1:0] meas_noise;
    logic [VAR_W-1:0]                 p_start;
    logic [EST_W-1:0]                 x_start;
  } kf_cfg_t;

  typedef struct packed {
    logic take;
    logic load;
    logic div_step;
    logic mul;
    logic wb;
    logic out_load;
  } kf_cmd_t;

  typedef struct packed {
    logic last_axis;
  } kf_sts_t;

endpackage

@@ design/kf_if.sv @@
// Valid/ready channel interfaces for measurement items and estimate items.
// Depends on kf_pkg for field widths.
interface kf_in_if import kf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] meas_x;
  logic signed [EST_W-1:0] meas_y;
  logic signed [EST_W-1:0] meas_z;
  logic                    restart;

  modport source (output valid, meas_x, meas_y, meas_z, restart, input ready);
  modport sink   (input valid, meas_x, meas_y, meas_z, restart, output ready);
endinterface

interface kf_out_if import kf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] est_x;
  logic signed [EST_W-1:0] est_y;
  logic signed [EST_W-1:0] est_z;

  modport source (output valid, est_x, est_y, est_z, input ready);
  modport sink   (input valid, est_x, est_y, est_z, output ready);
endinterface

@@ design/kf_cfg_regs.sv @@
// Configuration register bank: noise, restart variance and restart estimate.
// Depends on kf_pkg.
module kf_cfg_regs import kf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output kf_cfg_t               cfg
);

  kf_cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_PROC_X:  cfg_nxt.proc_noise[0] = cfg_data[VAR_W-1:0];
        REG_PROC_Y:  cfg_nxt.proc_noise[1] = cfg_data[VAR_W-1:0];
        REG_PROC_Z:  cfg_nxt.proc_noise[2] = cfg_data[VAR_W-1:0];
        REG_MEAS_X:  cfg_nxt.meas_noise[0] = cfg_data[VAR_W-1:0];
        REG_MEAS_Y:  cfg_nxt.meas_noise[1] = cfg_data[VAR_W-1:0];
        REG_MEAS_Z:  cfg_nxt.meas_noise[2] = cfg_data[VAR_W-1:0];
        REG_P_START: cfg_nxt.p_start       = cfg_data[VAR_W-1:0];
        REG_X_START: cfg_nxt.x_start       = cfg_data[EST_W-1:0];
        default:     cfg_nxt               = cfg_r; // drop writes beyond the bank
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.proc_noise <= {NOISE_AXES{PNOISE_RESET}};
      cfg_r.meas_noise <= {NOISE_AXES{MNOISE_RESET}};
      cfg_r.p_start    <= PSTART_RESET;
      cfg_r.x_start    <= XSTART_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ design/kf_ctrl.sv @@
// Controller: sequences load, gain division, multiply and write-back per axis,
// and owns both handshakes. Depends on kf_pkg.
module kf_ctrl import kf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  kf_sts_t sts,
  output kf_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_WB   = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] div_cnt_r, div_cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load    = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 5'd1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = sts.last_axis ? S_DONE : S_LOAD;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ design/kf_dpath.sv @@
// Datapath: per-axis state, restoring gain divider, estimate and variance
// multipliers, and the result register. Depends on kf_pkg.
module kf_dpath import kf_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  kf_cmd_t                 cmd,
  output kf_sts_t                 sts,
  input  kf_cfg_t                 cfg,
  input  logic signed [EST_W-1:0] meas_x,
  input  logic signed [EST_W-1:0] meas_y,
  input  logic signed [EST_W-1:0] meas_z,
  input  logic                    restart,
  output logic signed [EST_W-1:0] est_x,
  output logic signed [EST_W-1:0] est_y,
  output logic signed [EST_W-1:0] est_z
);

  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int OX  = 0 % AXES;
  localparam int OY  = 1 % AXES;
  localparam int OZ  = 2 % AXES;
  localparam int PE_W = EST_W + 1 + GAIN_W + 1;
  localparam int PV_W = GAIN_W + PRED_W;

  logic [NOISE_AXES-1:0][EST_W-1:0] meas_r;
  logic                    restart_r;
  logic [AXW-1:0]          axis_r;
  logic [1:0]              src_r;
  logic [EST_W-1:0]        est_mem_r [AXES];
  logic [VAR_W-1:0]        var_mem_r [AXES];
  logic [EST_W-1:0]        est_cur_r;
  logic [EST_W-1:0]        meas_cur_r;
  logic [PRED_W-1:0]       pred_r;
  logic [DEN_W-1:0]        den_r;
  logic [REM_W-1:0]        rem_r;
  logic [GAIN_W-1:0]       quo_r;
  logic                    zero_r;
  logic signed [PE_W-1:0]  prod_e_r;
  logic [PV_W-1:0]         prod_v_r;
  logic [EST_W-1:0]        est_x_r, est_y_r, est_z_r;

  logic [EST_W-1:0]        est_old;
  logic [VAR_W-1:0]        var_old;
  logic [PRED_W-1:0]       pred;
  logic [DEN_W-1:0]        den;
  logic                    qbit;
  logic [REM_W-1:0]        rem_sub;
  logic [GAIN_W-1:0]       gain;
  logic [GAIN_W-1:0]       inv_gain;
  logic signed [EST_W:0]   diff;
  logic signed [PE_W-1:0]  prod_e;
  logic [PV_W-1:0]         prod_v;
  logic [EST_W-1:0]        est_new;
  logic [DEN_W-1:0]        var_full;
  logic [VAR_W-1:0]        var_new;

  // operand fetch; restart substitutes the start values for every axis
  assign est_old = restart_r ? cfg.x_start : est_mem_r[axis_r];
  assign var_old = restart_r ? cfg.p_start : var_mem_r[axis_r];
  assign pred    = {1'b0, var_old} + {1'b0, cfg.proc_noise[src_r]};
  assign den     = {1'b0, pred} + {2'b0, cfg.meas_noise[src_r]};

  // one quotient bit per step; remainder stays below the divisor before the shift
  assign qbit    = (rem_r >= {1'b0, den_r});
  assign rem_sub = qbit ? (rem_r - {1'b0, den_r}) : rem_r;

  assign gain     = zero_r ? '0 : quo_r;
  assign inv_gain = ONE_Q16 - gain;
  assign diff     = $signed({meas_cur_r[EST_W-1], meas_cur_r})
                  - $signed({est_cur_r[EST_W-1], est_cur_r});
  assign prod_e   = diff * $signed({1'b0, gain});
  assign prod_v   = inv_gain * pred_r;

  // arithmetic slice of the product is the floor of the Q16 shift
  assign est_new  = est_cur_r + prod_e_r[EST_W+15:16];
  assign var_full = prod_v_r[PV_W-1:16];
  assign var_new  = (|var_full[DEN_W-1:VAR_W]) ? VAR_SAT : var_full[VAR_W-1:0];

  assign sts.last_axis = (axis_r == AXW'(AXES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= '0;
      src_r  <= '0;
    end else if (cmd.take) begin
      axis_r <= '0;
      src_r  <= '0;
    end else if (cmd.wb && !sts.last_axis) begin
      axis_r <= axis_r + AXW'(1);
      src_r  <= (src_r == 2'd2) ? 2'd0 : src_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        est_mem_r[i] <= '0;
        var_mem_r[i] <= VAR_RESET;
      end
    end else if (cmd.wb) begin
      est_mem_r[axis_r] <= est_new;
      var_mem_r[axis_r] <= var_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      meas_r[0] <= meas_x;
      meas_r[1] <= meas_y;
      meas_r[2] <= meas_z;
      restart_r <= restart;
    end
    if (cmd.load) begin
      est_cur_r  <= est_old;
      meas_cur_r <= meas_r[src_r];
      pred_r     <= pred;
      den_r      <= den;
      rem_r      <= {2'b0, pred};
      zero_r     <= (den == '0);
    end
    if (cmd.div_step) begin
      rem_r <= {rem_sub[REM_W-2:0], 1'b0};
      quo_r <= {quo_r[GAIN_W-2:0], qbit};
    end
    if (cmd.mul) begin
      prod_e_r <= prod_e;
      prod_v_r <= prod_v;
    end
    if (cmd.out_load) begin
      est_x_r <= est_mem_r[OX];
      est_y_r <= est_mem_r[OY];
      est_z_r <= est_mem_r[OZ];
    end
  end

  assign est_x = est_x_r;
  assign est_y = est_y_r;
  assign est_z = est_z_r;

endmodule

@@ design/three_axis_scalar_kalman_filter_core.sv @@
// Three-axis scalar Kalman filter core (random-walk model), Q15.16 / Q8.16.
// Items are worked one at a time; each axis takes one load, 17 steps of the shared
// restoring gain divider, one multiply, one write-back.
// Reset: synchronous, active low; clears estimates to zero, variances to 0.1,
// registers to their defaults and drops any pending result.
module three_axis_scalar_kalman_filter_core import kf_pkg::*; #(
  parameter int AXES = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  kf_in_if.sink                 in_ch,
  kf_out_if.source              out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  kf_cfg_t cfg;
  kf_cmd_t cmd;
  kf_sts_t sts;

  // register bank: to be written only while the core is idle, which the bank does not enforce; read by the datapath
  kf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // controller: accepts an item only when idle, but the result register
  // lets the next item in while the previous result still waits downstream
  kf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: axes are walked in turn through one divider and two multipliers
  kf_dpath #(
    .AXES (AXES)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg),
    .meas_x  (in_ch.meas_x),
    .meas_y  (in_ch.meas_y),
    .meas_z  (in_ch.meas_z),
    .restart (in_ch.restart),
    .est_x   (out_ch.est_x),
    .est_y   (out_ch.est_y),
    .est_z   (out_ch.est_z)
  );

endmodule

@@ design/kf_chk.sv @@
// Port-level checker for the Kalman filter core, bound to the top level.
// Depends on kf_pkg.
module kf_chk import kf_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [EST_W-1:0] est_x,
  input logic [EST_W-1:0] est_y,
  input logic [EST_W-1:0] est_z
);

  // an accepted item keeps the input closed while the axes are worked
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready)
    else $error("input reopened too soon after an accepted item");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(est_x) && $stable(est_y) && $stable(est_z)))
    else $error("stalled result changed or vanished");

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind three_axis_scalar_kalman_filter_core kf_chk u_kf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .est_x     (out_ch.est_x),
  .est_y     (out_ch.est_y),
  .est_z     (out_ch.est_z)
);
